### design/tcfs_pkg.sv
// Shared types and constants for the triangle cull and flat shade pipeline.
// No dependencies; every other design file imports this package.
`default_nettype none

package tcfs_pkg;

  localparam int COORD_W          = 18;
  localparam int TAG_W            = 16;
  localparam int LVL_W            = 8;
  localparam int NORMAL_FRAC_BITS = 15;

  // Stream widths, padded to whole bytes.
  localparam int IN_W  = 184;
  localparam int OUT_W = 64;

  // The largest normal magnitude after rescaling lies in [2^23, 2^24) unless the normal is zero.
  localparam int M_W    = 24;
  localparam int SQ_W   = 2 * M_W + 2;
  localparam int ROOT_W = M_W + 1;
  localparam int QUO_W  = NORMAL_FRAC_BITS + 1;

  localparam int OUT_PAD_W = OUT_W - (TAG_W + 2 + COORD_W + 3 * LVL_W);

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               visible;
    logic               degenerate;
    logic [COORD_W-1:0] depth;
    logic [2:0]         neg;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [2:0][M_W-1:0]    m;
  } norm_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [LVL_W-1:0]     red;
    logic [LVL_W-1:0]     green;
    logic [LVL_W-1:0]     blue;
    logic [COORD_W-1:0]   depth;
    logic                 degenerate;
    logic                 visible;
    logic [TAG_W-1:0]     tag;
  } out_t;

endpackage

`default_nettype wire

### design/tcfs_front.sv
// Front end: edge vectors, exact cross product, rounded mean depth, and the
// rescaled normal with its squared length. Depends on tcfs_pkg.
`default_nettype none

module tcfs_front
  import tcfs_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][2:0][COORD_W-1:0]    vtx,
  input  logic [TAG_W-1:0]                tag,
  output logic                            out_valid,
  output norm_t                           out_nrm,
  output logic [SQ_W-1:0]                 out_q
);

  localparam int DIFF_W      = COORD_W + 1;
  localparam int ZSUM_W      = COORD_W + 2;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int NV_W        = PROD_W + 1;
  localparam int POS_W       = $clog2(NV_W);
  localparam int DNUM_W      = COORD_W + 4;
  localparam int DRECIP_W    = DNUM_W + 1;
  localparam int DPROD_W     = DNUM_W + DRECIP_W;
  localparam int DSHIFT      = DNUM_W + 3;
  localparam int DEPTH_BIAS  = 6 * (1 << COORD_W);
  localparam logic [DRECIP_W-1:0] DRECIP = DRECIP_W'(((1 << DSHIFT) + 5) / 6);

  localparam int NSTG = 8;

  logic  vld [1:NSTG];
  side_t sd  [1:NSTG];

  logic signed [DIFF_W-1:0]  u [3];
  logic signed [DIFF_W-1:0]  w [3];
  logic signed [ZSUM_W-1:0]  zsum;
  logic signed [PROD_W-1:0]  p [6];
  logic [DNUM_W-1:0]         dnum;
  logic signed [NV_W-1:0]    nv [3];
  logic [DPROD_W-1:0]        dprod;
  logic [NV_W-1:0]           mag [3];
  logic [NV_W-1:0]           orv;
  logic [NV_W-1:0]           mag5 [3];
  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          pos_c;
  logic [2:0][M_W-1:0]       m6;
  logic [2:0][M_W-1:0]       m7;
  logic [2:0][M_W-1:0]       m8;
  logic [2*M_W-1:0]          sq [3];
  logic [SQ_W-1:0]           q;
  logic signed [DNUM_W:0]    dn_c;
  logic [NV_W-1:0]           shifted [3];

  always_comb begin
    dn_c = ((DNUM_W+1)'(zsum) <<< 1) + (DNUM_W+1)'(DEPTH_BIAS + 3);
  end

  // Highest set bit of the OR of the magnitudes is the highest bit of the largest.
  always_comb begin
    pos_c = '0;
    for (int b = 0; b < NV_W; b++) begin
      if (orv[b]) begin
        pos_c = POS_W'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos >= POS_W'(M_W - 1)) begin
        shifted[i] = mag5[i] >> (pos - POS_W'(M_W - 1));
      end else begin
        shifted[i] = mag5[i] << (POS_W'(M_W - 1) - pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Edge vectors b - a and b - c, and the z sum.
      for (int a = 0; a < 3; a++) begin
        u[a] <= DIFF_W'($signed(vtx[1][a])) - DIFF_W'($signed(vtx[0][a]));
        w[a] <= DIFF_W'($signed(vtx[1][a])) - DIFF_W'($signed(vtx[2][a]));
      end
      zsum <= ZSUM_W'($signed(vtx[0][2])) + ZSUM_W'($signed(vtx[1][2]))
            + ZSUM_W'($signed(vtx[2][2]));
      sd[1] <= '{tag: tag, visible: 1'b0, degenerate: 1'b0, depth: '0, neg: '0};

      p[0] <= PROD_W'(u[1]) * PROD_W'(w[2]);
      p[1] <= PROD_W'(u[2]) * PROD_W'(w[1]);
      p[2] <= PROD_W'(u[2]) * PROD_W'(w[0]);
      p[3] <= PROD_W'(u[0]) * PROD_W'(w[2]);
      p[4] <= PROD_W'(u[0]) * PROD_W'(w[1]);
      p[5] <= PROD_W'(u[1]) * PROD_W'(w[0]);
      dnum <= dn_c[DNUM_W-1:0];

      nv[0] <= NV_W'(p[0]) - NV_W'(p[1]);
      nv[1] <= NV_W'(p[2]) - NV_W'(p[3]);
      nv[2] <= NV_W'(p[4]) - NV_W'(p[5]);
      dprod <= DPROD_W'(dnum) * DPROD_W'(DRECIP);

      for (int i = 0; i < 3; i++) begin
        mag[i] <= nv[i][NV_W-1] ? NV_W'(-nv[i]) : NV_W'(nv[i]);
      end
      orv <= (nv[0][NV_W-1] ? NV_W'(-nv[0]) : NV_W'(nv[0]))
           | (nv[1][NV_W-1] ? NV_W'(-nv[1]) : NV_W'(nv[1]))
           | (nv[2][NV_W-1] ? NV_W'(-nv[2]) : NV_W'(nv[2]));

      pos <= pos_c;
      for (int i = 0; i < 3; i++) begin
        mag5[i] <= mag[i];
      end

      for (int i = 0; i < 3; i++) begin
        m6[i] <= shifted[i][M_W-1:0];
      end

      for (int i = 0; i < 3; i++) begin
        sq[i] <= (2*M_W)'(m6[i]) * (2*M_W)'(m6[i]);
      end
      m7 <= m6;

      q  <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
      m8 <= m7;

      sd[2] <= sd[1];
      sd[3] <= sd[2];
      // The bias added before the reciprocal multiply only touches bits above the depth.
      sd[4] <= '{tag:        sd[3].tag,
                 visible:    !((nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0))
                             && (nv[2][NV_W-1] || (nv[2] == '0)),
                 degenerate: (nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0),
                 depth:      dprod[DSHIFT +: COORD_W],
                 neg:        {nv[2][NV_W-1], nv[1][NV_W-1], nv[0][NV_W-1]}};
      for (int k = 5; k <= NSTG; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid    = vld[NSTG];
  assign out_nrm.side = sd[NSTG];
  assign out_nrm.m    = m8;
  assign out_q        = q;

endmodule

`default_nettype wire

### design/tcfs_isqrt.sv
// Pipelined integer square root, one result bit per stage, of the squared
// normal length. Carries the normal and sideband alongside. Depends on tcfs_pkg.
`default_nettype none

module tcfs_isqrt
  import tcfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  norm_t             in_nrm,
  input  logic [SQ_W-1:0]   in_q,
  output logic              out_valid,
  output norm_t             out_nrm,
  output logic [ROOT_W-1:0] out_root
);

  localparam int TR_W = SQ_W + 2;

  logic              vld  [0:ROOT_W];
  norm_t             nrm  [0:ROOT_W];
  logic [SQ_W-1:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign nrm[0]  = in_nrm;
  assign rem[0]  = in_q;
  assign root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int BIT = ROOT_W - 1 - k;
    logic [TR_W-1:0] trial;

    // (r + 2^b)^2 - r^2 for the bits decided so far.
    assign trial = ((TR_W'(root[k]) << 1) + (TR_W'(1) << BIT)) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm[k+1] <= nrm[k];
        if (TR_W'(rem[k]) >= trial) begin
          rem[k+1]  <= rem[k] - trial[SQ_W-1:0];
          root[k+1] <= root[k] | (ROOT_W'(1) << BIT);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_nrm   = nrm[ROOT_W];
  assign out_root  = root[ROOT_W];

endmodule

`default_nettype wire

### design/tcfs_div.sv
// Three-lane pipelined restoring divider that forms the unit normal
// magnitudes, rounded to nearest, one quotient bit per stage. Depends on tcfs_pkg.
`default_nettype none

module tcfs_div
  import tcfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  norm_t                 in_nrm,
  input  logic [ROOT_W-1:0]     in_root,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [2:0][QUO_W-1:0] out_quo
);

  localparam int NUM_W = M_W + NORMAL_FRAC_BITS + 1;

  logic                  vld [0:QUO_W];
  side_t                 sd  [0:QUO_W];
  logic [ROOT_W-1:0]     dvs [0:QUO_W];
  logic [2:0][NUM_W-1:0] rem [0:QUO_W];
  logic [2:0][QUO_W-1:0] quo [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // Adding half the divisor makes the truncating quotient round to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]  <= in_nrm.side;
      dvs[0] <= in_root;
      quo[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= (NUM_W'(in_nrm.m[i]) << NORMAL_FRAC_BITS) + NUM_W'(in_root >> 1);
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - 1 - k;
    logic [NUM_W-1:0] sub;

    assign sub = NUM_W'(dvs[k]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]  <= sd[k];
        dvs[k+1] <= dvs[k];
        for (int i = 0; i < 3; i++) begin
          if (rem[k][i] >= sub) begin
            rem[k+1][i] <= rem[k][i] - sub;
            quo[k+1][i] <= quo[k][i] | (QUO_W'(1) << BIT);
          end else begin
            rem[k+1][i] <= rem[k][i];
            quo[k+1][i] <= quo[k][i];
          end
        end
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_side  = sd[QUO_W];
  assign out_quo   = quo[QUO_W];

endmodule

`default_nettype wire

### design/tcfs_shade.sv
// Specular shading: reflected light term, its fourth power, and the two
// distinct colour levels with saturation. Depends on tcfs_pkg.
`default_nettype none

module tcfs_shade
  import tcfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic [2:0][QUO_W-1:0] in_quo,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [LVL_W-1:0]      out_blue,
  output logic [LVL_W-1:0]      out_green
);

  localparam int NF       = NORMAL_FRAC_BITS;
  localparam int NS_W     = QUO_W + 1;
  localparam int SDOT_W   = NS_W + 2;
  localparam int DOT_W    = SDOT_W + NS_W;
  localparam int T_W      = DOT_W + 2;
  localparam int A1_W     = NF + 3;
  localparam int SQ1_W    = 2 * A1_W;
  localparam int T2_W     = NF + 6;
  localparam int SQ2_W    = 2 * T2_W;
  localparam int T4_W     = SQ2_W - NF;
  localparam int LNUM_W   = T4_W + 3;
  localparam int DEN_W    = NF + 6;
  localparam int X_W      = DEN_W + 8;
  localparam int Y_W      = X_W - NF;
  localparam int RCP_W    = 14;
  localparam int YP_W     = Y_W + RCP_W;
  localparam int LVL_SHIFT = 19;
  localparam int LVL_MAX  = (1 << LVL_W) - 1;
  localparam int DEN      = 45 << NF;
  localparam int HALF_DEN = DEN / 2;
  localparam int BASE_BLUE  = 27 << NF;
  localparam int BASE_GREEN = 9 << NF;
  localparam logic [RCP_W-1:0] LVL_RECIP = RCP_W'(((1 << LVL_SHIFT) + 44) / 45);
  localparam int NSTG = 9;

  logic  vld [1:NSTG];
  side_t sd  [1:NSTG];

  logic signed [NS_W-1:0]   ns [3];
  logic signed [SDOT_W-1:0] sdot;
  logic signed [NS_W-1:0]   nz;
  logic signed [DOT_W-1:0]  dot;
  logic signed [T_W-1:0]    t_c;
  logic [T_W-1:0]           tmag_c;
  logic [A1_W-1:0]          a1;
  logic [SQ1_W-1:0]         sq1;
  logic [T2_W-1:0]          t2_c;
  logic [SQ2_W-1:0]         sq2;
  logic [T4_W-1:0]          t4_c;
  logic [LNUM_W-1:0]        lb_c;
  logic [LNUM_W-1:0]        lg_c;
  logic [DEN_W-1:0]         nb;
  logic [DEN_W-1:0]         ng;
  logic [X_W-1:0]           xb;
  logic [X_W-1:0]           xg;
  logic [YP_W-1:0]          ypb;
  logic [YP_W-1:0]          ypg;
  logic [2:0]               sat_b;
  logic [2:0]               sat_g;
  logic [LVL_W-1:0]         blue;
  logic [LVL_W-1:0]         green;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_side.neg[i]) begin
        ns[i] = -$signed({1'b0, in_quo[i]});
      end else begin
        ns[i] = $signed({1'b0, in_quo[i]});
      end
    end
  end

  // t holds 2*(nx - ny + nz)*nz - 1 with twice the normal fraction bits.
  always_comb begin
    t_c    = (T_W'(dot) <<< 1) - (T_W'(1) << (2 * NF));
    tmag_c = t_c[T_W-1] ? T_W'(-t_c) : T_W'(t_c);
    t2_c   = T2_W'(((SQ1_W+1)'(sq1) + (SQ1_W+1)'(1 << (NF - 1))) >> NF);
    t4_c   = T4_W'(((SQ2_W+1)'(sq2) + (SQ2_W+1)'(1 << (NF - 1))) >> NF);
    lb_c   = (LNUM_W'(t4_c) << 2) + LNUM_W'(BASE_BLUE);
    lg_c   = (LNUM_W'(t4_c) << 2) + LNUM_W'(BASE_GREEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= in_side;
      for (int k = 2; k <= NSTG; k++) begin
        sd[k] <= sd[k-1];
      end

      sdot <= SDOT_W'(ns[0]) - SDOT_W'(ns[1]) + SDOT_W'(ns[2]);
      nz   <= ns[2];

      dot <= DOT_W'(sdot) * DOT_W'(nz);

      a1 <= A1_W'((tmag_c + T_W'(1 << (NF - 1))) >> NF);

      sq1 <= SQ1_W'(a1) * SQ1_W'(a1);

      sq2 <= SQ2_W'(t2_c) * SQ2_W'(t2_c);

      // A level of one or more saturates; below that the numerator fits DEN_W bits.
      sat_b[0] <= lb_c >= LNUM_W'(DEN);
      sat_g[0] <= lg_c >= LNUM_W'(DEN);
      nb <= lb_c[DEN_W-1:0];
      ng <= lg_c[DEN_W-1:0];

      xb <= X_W'(nb) * X_W'(LVL_MAX) + X_W'(HALF_DEN);
      xg <= X_W'(ng) * X_W'(LVL_MAX) + X_W'(HALF_DEN);
      sat_b[1] <= sat_b[0];
      sat_g[1] <= sat_g[0];

      // Division by 45 through a reciprocal, exact over the range of the quotient.
      ypb <= YP_W'(xb[X_W-1:NF]) * YP_W'(LVL_RECIP);
      ypg <= YP_W'(xg[X_W-1:NF]) * YP_W'(LVL_RECIP);
      sat_b[2] <= sat_b[1];
      sat_g[2] <= sat_g[1];

      if (sd[8].degenerate) begin
        blue  <= '0;
        green <= '0;
      end else begin
        blue  <= sat_b[2] ? LVL_W'(LVL_MAX) : ypb[LVL_SHIFT +: LVL_W];
        green <= sat_g[2] ? LVL_W'(LVL_MAX) : ypg[LVL_SHIFT +: LVL_W];
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign out_side  = sd[NSTG];
  assign out_blue  = blue;
  assign out_green = green;

endmodule

`default_nettype wire

### design/triangle_cull_and_flat_shade_top.sv
// Top level of the triangle cull and flat shade block: stream ports, the
// four pipeline sections and the output register with its skid stage.
// Depends on tcfs_pkg, tcfs_front, tcfs_isqrt, tcfs_div and tcfs_shade.
`default_nettype none

// One triangle enters per clock cycle while the skid stage is empty. Each
// result passes through 8 stages of cross product and normal rescaling, a
// 25-stage square root that resolves one bit per stage, a 17-stage divider
// that loads its operands and then resolves one quotient bit per stage for
// all three normal components, 9 stages of shading and the output register.
// When the output stalls, the skid stage takes one more result and the input
// then holds s_tready low until the skid stage drains.
module triangle_cull_and_flat_shade_top
  import tcfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z (18 bits each), triangle_tag, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // tag_out, visible, degenerate, mean_depth, blue_level, green_level,
  // red_level, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  logic                  en;
  logic                  f_valid;
  norm_t                 f_nrm;
  logic [SQ_W-1:0]       f_q;
  logic                  r_valid;
  norm_t                 r_nrm;
  logic [ROOT_W-1:0]     r_root;
  logic                  d_valid;
  side_t                 d_side;
  logic [2:0][QUO_W-1:0] d_quo;
  logic                  p_valid;
  side_t                 p_side;
  logic [LVL_W-1:0]      p_blue;
  logic [LVL_W-1:0]      p_green;
  out_t                  p_data;
  logic                  p_fire;
  logic                  o_valid;
  out_t                  o_data;
  logic                  skid_valid;
  out_t                  skid_data;

  // The whole pipeline moves together while the skid stage is empty.
  assign en       = !skid_valid;
  assign s_tready = en;

  tcfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .vtx       (s_tdata[9*COORD_W-1:0]),
    .tag       (s_tdata[9*COORD_W +: TAG_W]),
    .out_valid (f_valid),
    .out_nrm   (f_nrm),
    .out_q     (f_q)
  );

  tcfs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_nrm    (f_nrm),
    .in_q      (f_q),
    .out_valid (r_valid),
    .out_nrm   (r_nrm),
    .out_root  (r_root)
  );

  tcfs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_nrm    (r_nrm),
    .in_root   (r_root),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quo   (d_quo)
  );

  tcfs_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_quo    (d_quo),
    .out_valid (p_valid),
    .out_side  (p_side),
    .out_blue  (p_blue),
    .out_green (p_green)
  );

  always_comb begin
    p_data            = '0;
    p_data.tag        = p_side.tag;
    p_data.visible    = p_side.visible;
    p_data.degenerate = p_side.degenerate;
    p_data.depth      = p_side.depth;
    p_data.blue       = p_blue;
    p_data.green      = p_green;
    p_data.red        = p_green;
  end

  assign p_fire = p_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!o_valid || m_tready) begin
      if (skid_valid) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        o_valid <= p_fire;
      end
    end else if (p_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || m_tready) begin
      if (skid_valid) begin
        o_data <= skid_data;
      end else if (p_fire) begin
        o_data <= p_data;
      end
    end else if (p_fire) begin
      skid_data <= p_data;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> o_valid)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(o_valid && !m_tready))
    else $error("skid stage filled without an output stall");

  a_degen_dark: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_data.degenerate) |->
      (!o_data.visible && o_data.blue == '0 && o_data.green == '0 && o_data.red == '0))
    else $error("degenerate triangle reported visible or shaded");

  a_blue_ge_green: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_data.degenerate) |-> (o_data.blue >= o_data.green))
    else $error("blue level below green level despite larger diffuse term");
`endif

endmodule

`default_nettype wire
